// ===== hdl/fpk_pkg.sv =====
// ----------------------------------------------------------------------------
// fpk_pkg
// Shared types and constants for the flash row packer.
// ----------------------------------------------------------------------------
package fpk_pkg;

    // Row size in bytes. It must be a power of two in the range 8 to 256.
    localparam int ROW_BYTES_DEF = 128;

    // Opcodes
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Result status codes
    localparam logic ST_WORD  = 1'b0;
    localparam logic ST_ERROR = 1'b1;

    // A flush restarts the row at this address.
    localparam logic [31:0] FLUSH_BASE = 32'hFFFF_FF00;
    // Blank fill by byte position mod 4: FF FF FF 00, lowest byte first.
    localparam logic [31:0] BLANK_WORD = 32'h00FF_FFFF;

    typedef struct packed {
        logic        opcode;
        logic [31:0] address;
        logic [7:0]  data_byte;
    } t_in;

    typedef struct packed {
        logic [31:0] row_address;
        logic [5:0]  word_index;
        logic [31:0] row_word;
        logic        status;
        logic        last;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_FILL,
        S_EMIT_RD,
        S_EMIT,
        S_ERR
    } t_state;

    // What the current input does once its row work is done
    typedef enum logic [1:0] {
        KIND_APPEND,
        KIND_JUMP,
        KIND_FLUSH
    } t_kind;

    // Source of the address at which a new row starts
    typedef enum logic [1:0] {
        BASE_ADDR,
        BASE_END,
        BASE_FLUSH
    } t_base;

    typedef struct packed {
        logic  load_in;     // capture the input beat
        logic  set_append;  // plan an in-row append up to the input address
        logic  start_row;   // start a new row, plan its blank prefix
        t_base base;        // start address source for start_row
        logic  fill_step;   // write one word of blank fill / data
        logic  emit_first;  // read word 0 of the row
        logic  emit_load;   // load one row word into the output register
        logic  err_load;    // load an error result
    } t_cmd;

    typedef struct packed {
        logic opcode;     // opcode of the held input
        logic below;      // address below the current row
        logic in_row;     // address inside the current row
        logic behind;     // address below the fill position
        logic full;       // row holds ROW_BYTES bytes
        logic empty;      // row holds no byte
        logic fill_done;  // fill position reached the planned end
        logic emit_last;  // word being emitted is the last one
        logic out_free;   // output register can take a result
    } t_sts;

endpackage

// ===== hdl/fpk_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpk_ctrl
// Sequencer: decodes each input and steps the datapath through
// fill, emit and restart.
// ----------------------------------------------------------------------------
module fpk_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fpk_pkg::t_sts i_sts,
    output fpk_pkg::t_cmd o_cmd
);

    fpk_pkg::t_state r_state, n_state;
    fpk_pkg::t_kind  r_kind,  n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpk_pkg::S_IDLE;
            r_kind  <= fpk_pkg::KIND_APPEND;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_kind           = r_kind;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.base       = fpk_pkg::BASE_ADDR;

        case (r_state)
            fpk_pkg::S_IDLE: begin
                // no beat is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = fpk_pkg::S_DECIDE;
                end
            end

            fpk_pkg::S_DECIDE: begin
                if (i_sts.opcode == fpk_pkg::OP_FLUSH) begin
                    n_kind = fpk_pkg::KIND_FLUSH;
                    if (!i_sts.empty) begin
                        n_state = fpk_pkg::S_EMIT_RD;
                    end else begin
                        o_cmd.start_row = 1'b1;
                        o_cmd.base      = fpk_pkg::BASE_FLUSH;
                        n_state         = fpk_pkg::S_FILL;
                    end
                end else if (i_sts.below) begin
                    n_state = fpk_pkg::S_ERR;
                end else if (i_sts.in_row) begin
                    if (i_sts.behind || i_sts.full) begin
                        n_state = fpk_pkg::S_ERR;
                    end else begin
                        o_cmd.set_append = 1'b1;
                        n_kind           = fpk_pkg::KIND_APPEND;
                        n_state          = fpk_pkg::S_FILL;
                    end
                end else begin
                    n_kind = fpk_pkg::KIND_JUMP;
                    if (!i_sts.empty) begin
                        n_state = fpk_pkg::S_EMIT_RD;
                    end else begin
                        o_cmd.start_row = 1'b1;
                        o_cmd.base      = fpk_pkg::BASE_ADDR;
                        n_state         = fpk_pkg::S_FILL;
                    end
                end
            end

            fpk_pkg::S_FILL: begin
                if (!i_sts.fill_done) begin
                    o_cmd.fill_step = 1'b1;
                end else if (r_kind == fpk_pkg::KIND_APPEND && i_sts.full) begin
                    n_state = fpk_pkg::S_EMIT_RD;
                end else begin
                    n_state = fpk_pkg::S_IDLE;
                end
            end

            fpk_pkg::S_EMIT_RD: begin
                o_cmd.emit_first = 1'b1;
                n_state          = fpk_pkg::S_EMIT;
            end

            fpk_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_sts.emit_last) begin
                        o_cmd.start_row = 1'b1;
                        case (r_kind)
                            fpk_pkg::KIND_FLUSH:  o_cmd.base = fpk_pkg::BASE_FLUSH;
                            fpk_pkg::KIND_JUMP:   o_cmd.base = fpk_pkg::BASE_ADDR;
                            default:              o_cmd.base = fpk_pkg::BASE_END;
                        endcase
                        n_state = fpk_pkg::S_FILL;
                    end
                end
            end

            fpk_pkg::S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.err_load = 1'b1;
                    n_state        = fpk_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = fpk_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/fpk_dp.sv =====
// ----------------------------------------------------------------------------
// fpk_dp
// Datapath: input hold register, row state, word-wide row memory with
// byte enables, emit counter and output register.
// ----------------------------------------------------------------------------
module fpk_dp #(
    parameter int ROW_BYTES = fpk_pkg::ROW_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fpk_pkg::t_in  i_in_data,
    input  fpk_pkg::t_cmd i_cmd,
    output fpk_pkg::t_sts o_sts,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output fpk_pkg::t_out o_out_data
);

    localparam int LOG    = $clog2(ROW_BYTES);
    localparam int FILL_W = LOG + 1;
    localparam int WIDX   = LOG - 2;
    localparam int WORDS  = ROW_BYTES / 4;

    fpk_pkg::t_in      r_in;
    logic [31:0]       r_row_start;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_fend;     // fill position after the planned writes
    logic              r_fhas;     // last planned position takes the data byte
    logic [WIDX-1:0]   r_k;
    logic [31:0]       r_rd;
    logic              r_out_valid;
    fpk_pkg::t_out     r_out;

    logic [31:0]       mem [WORDS];

    // fill step
    logic [WIDX-1:0]   w;
    logic [WIDX:0]     w1;
    logic [FILL_W-1:0] bound;
    logic [FILL_W-1:0] n_fill_step;
    logic [FILL_W-1:0] dpos;
    logic [FILL_W-1:0] pos;
    logic [3:0]        be;
    logic [31:0]       wd;

    // row start
    logic [31:0]       base;
    logic [31:0]       row_end;

    // emit
    logic [WIDX-1:0]   last_k;
    logic [FILL_W-1:0] fill_m1;
    logic [FILL_W-1:0] epos;
    logic [31:0]       emit_word;
    logic              rd_en;
    logic [WIDX-1:0]   rd_addr;

    assign row_end = r_row_start + 32'(ROW_BYTES);

    always_comb begin
        case (i_cmd.base)
            fpk_pkg::BASE_END:   base = row_end;
            fpk_pkg::BASE_FLUSH: base = fpk_pkg::FLUSH_BASE;
            default:             base = r_in.address;
        endcase
    end

    // One word of blank fill, with the data byte at the last planned position.
    always_comb begin
        w     = r_fill[LOG-1:2];
        w1    = {1'b0, w} + 1'b1;
        bound = {w1, 2'b00};
        dpos  = r_fend - 1'b1;
        n_fill_step = (bound < r_fend) ? bound : r_fend;
        for (int b = 0; b < 4; b++) begin
            pos       = {1'b0, w, 2'(b)};
            be[b]     = i_cmd.fill_step && (pos >= r_fill) && (pos < r_fend);
            wd[8*b +: 8] = (r_fhas && pos == dpos) ? r_in.data_byte
                                                  : fpk_pkg::BLANK_WORD[8*b +: 8];
        end
    end

    // Row word with positions past the fill count forced to blank.
    always_comb begin
        fill_m1 = r_fill - 1'b1;
        last_k  = fill_m1[LOG-1:2];
        for (int b = 0; b < 4; b++) begin
            epos = {1'b0, r_k, 2'(b)};
            emit_word[8*b +: 8] = (epos < r_fill) ? r_rd[8*b +: 8]
                                                  : fpk_pkg::BLANK_WORD[8*b +: 8];
        end
        rd_en   = i_cmd.emit_first || i_cmd.emit_load;
        rd_addr = i_cmd.emit_first ? '0 : r_k + 1'b1;
    end

    // Row memory: byte-enabled write, registered read
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 4; b++) begin
            if (be[b]) begin
                mem[w][8*b +: 8] <= wd[8*b +: 8];
            end
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Input hold and emit counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
        if (i_cmd.emit_first) begin
            r_k <= '0;
        end else if (i_cmd.emit_load) begin
            r_k <= r_k + 1'b1;
        end
    end

    // Row state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_start <= '0;
            r_fill      <= '0;
            r_fend      <= '0;
            r_fhas      <= 1'b0;
        end else if (i_cmd.start_row) begin
            r_row_start <= base & ~(32'(ROW_BYTES) - 32'd1);
            r_fill      <= '0;
            r_fend      <= FILL_W'(base[LOG-1:0])
                           + FILL_W'(i_cmd.base == fpk_pkg::BASE_ADDR);
            r_fhas      <= (i_cmd.base == fpk_pkg::BASE_ADDR);
        end else if (i_cmd.set_append) begin
            r_fend <= FILL_W'(r_in.address[LOG-1:0]) + 1'b1;
            r_fhas <= 1'b1;
        end else if (i_cmd.fill_step) begin
            r_fill <= n_fill_step;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load || i_cmd.err_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out.row_address <= r_row_start;
            r_out.word_index  <= 6'(r_k);
            r_out.row_word    <= emit_word;
            r_out.status      <= fpk_pkg::ST_WORD;
            r_out.last        <= (r_k == last_k);
        end else if (i_cmd.err_load) begin
            r_out.row_address <= '0;
            r_out.word_index  <= '0;
            r_out.row_word    <= '0;
            r_out.status      <= fpk_pkg::ST_ERROR;
            r_out.last        <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_sts.opcode    = r_in.opcode;
        o_sts.below     = r_in.address[31:LOG] < r_row_start[31:LOG];
        o_sts.in_row    = r_in.address[31:LOG] == r_row_start[31:LOG];
        o_sts.behind    = {1'b0, r_in.address[LOG-1:0]} < r_fill;
        o_sts.full      = r_fill == FILL_W'(ROW_BYTES);
        o_sts.empty     = r_fill == '0;
        o_sts.fill_done = r_fill == r_fend;
        o_sts.emit_last = r_k == last_k;
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

endmodule

// ===== hdl/flash_row_packer.sv =====
// ----------------------------------------------------------------------------
// flash_row_packer
// Packs addressed data bytes into aligned flash rows and reads each row
// out as 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one beat per
//   item: a data byte with its address, or a flush. Output channel
//   (o_out_valid / i_out_ready / o_out_data) gives row words, lowest address
//   in the low byte, or a one-beat error for a byte below the row, behind
//   the fill position or in a full row. An item's last beat has last = 1.
// Sequence:
//   An item is captured and decoded; then each row word that takes blank
//   bytes or the data byte is written (at most ROW_BYTES/4 words) and the
//   end of the fill is checked. When a row goes out, the memory read is
//   primed and the words are emitted one after another.
// Reset:
//   Synchronous, active low. Row start and fill count clear; the row memory
//   is not cleared, only filled positions are ever read.
// Stalls:
//   A result sits in the output register; a new item is taken while it
//   waits. Row readout pauses word by word while the receiver stalls.
// ROW_BYTES must be a power of two from 8 to 256.
// ----------------------------------------------------------------------------
module flash_row_packer #(
    parameter int ROW_BYTES = fpk_pkg::ROW_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fpk_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output fpk_pkg::t_out o_out_data
);

    fpk_pkg::t_cmd cmd;
    fpk_pkg::t_sts sts;

    // Sequencer: one item at a time
    fpk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Row memory, row state and output register
    fpk_dp #(
        .ROW_BYTES (ROW_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // An error beat is always a lone, zeroed, final beat.
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == fpk_pkg::ST_ERROR) |->
        (o_out_data.last && o_out_data.row_word == '0 && o_out_data.word_index == '0))
        else $error("error beat malformed");

    // Never read out an empty row.
    a_no_empty_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_load |-> !sts.empty)
        else $error("empty row emitted");

    // Fill writes only while short of the planned end.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fill_step |-> !sts.fill_done)
        else $error("fill step past end");

    // In the cycle after an accepted beat the block is busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("accepted beat while busy");
`endif

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for flash_row_packer. Addressed bytes and flushes are
// sent through a valid/ready driver. A row-buffer model predicts every row
// word and every error beat. The output monitor checks them in order, field
// by field. Idling on both sides moves through three phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_BYTES    = fpk_pkg::ROW_BYTES_DEF;
    localparam int RANDOM_ITEMS = 330;
    // Worst quiet stretch of a correct run: a prefix fill of up to
    // ROW_BYTES/4 words plus the control states, without a beat. On top of
    // that comes a receiver stall at 85% idle. The limit leaves a wide margin
    // over both.
    localparam int STALL_LIMIT  = 4000;
    // Settle time after the last expected beat. An item that makes no beat
    // can still be filling its row.
    localparam int DRAIN_CYCLES = 200;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_ready;
    fpk_pkg::t_in  in_beat   = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    fpk_pkg::t_out out_beat;

    fpk_pkg::t_in  item_q[$];          // items waiting for the driver
    fpk_pkg::t_out row_out_q[$];       // predicted output beats, oldest first
    int unsigned   item_total  = 0;
    int unsigned   sent_cnt    = 0;
    int unsigned   idle_cycles = 0;
    int            fail_cnt    = 0;

    // Row model: byte image of the open row, its aligned base and fill level.
    logic [7:0]  row_img [ROW_BYTES];
    logic [31:0] row_base = '0;
    int unsigned row_fill = 0;

    flash_row_packer #(.ROW_BYTES(ROW_BYTES)) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_beat),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_beat)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Row model
    // ------------------------------------------------------------------

    // Blank pattern by byte position: FF FF FF 00
    function automatic logic [7:0] blank_byte(int unsigned pos);
        return (pos % 4 == 3) ? 8'h00 : 8'hFF;
    endfunction

    // Read out the open row: one beat per started word. Bytes past the
    // fill level are blank, so unwritten image entries are never used.
    task automatic push_row_words();
        int unsigned   nwords;
        int unsigned   k;
        int unsigned   b;
        int unsigned   p;
        fpk_pkg::t_out beat;
        nwords = (row_fill + 3) / 4;
        for (k = 0; k < nwords; k++) begin
            beat             = '0;
            beat.row_address = row_base;
            beat.word_index  = 6'(k);
            beat.status      = fpk_pkg::ST_WORD;
            for (b = 0; b < 4; b++) begin
                p = k * 4 + b;
                beat.row_word[8*b +: 8] = (p < row_fill) ? row_img[p] : blank_byte(p);
            end
            row_out_q.push_back(beat);
        end
    endtask

    // New row at the aligned address; positions below addr are blank.
    task automatic open_row(logic [31:0] addr);
        int unsigned off;
        int unsigned i;
        off      = addr % ROW_BYTES;
        row_base = addr - off;
        for (i = 0; i < off; i++)
            row_img[i] = blank_byte(i);
        row_fill = off;
    endtask

    task automatic push_error();
        fpk_pkg::t_out beat;
        beat        = '0;
        beat.status = fpk_pkg::ST_ERROR;
        beat.last   = 1'b1;
        row_out_q.push_back(beat);
    endtask

    // Predict the beats of one accepted item and advance the row model.
    task automatic pack_item(fpk_pkg::t_in it);
        logic [32:0]   row_end;
        logic [32:0]   fill_pos;
        int unsigned   target;
        int            n0;
        fpk_pkg::t_out tail;
        n0       = row_out_q.size();
        // 33 bits so the top row's end does not wrap
        row_end  = {1'b0, row_base} + ROW_BYTES;
        fill_pos = {1'b0, row_base} + row_fill;
        if (it.opcode == fpk_pkg::OP_FLUSH) begin
            // an empty row gives no beat but still restarts
            if (row_fill != 0)
                push_row_words();
            open_row(fpk_pkg::FLUSH_BASE);
        end else if (it.address < row_base) begin
            push_error();
        end else if ({1'b0, it.address} < row_end) begin
            // behind the fill level, or row already full from a jump
            if ({1'b0, it.address} < fill_pos || row_fill >= ROW_BYTES) begin
                push_error();
            end else begin
                target = it.address - row_base;
                while (row_fill < target) begin
                    row_img[row_fill] = blank_byte(row_fill);
                    row_fill++;
                end
                row_img[row_fill] = it.data_byte;
                row_fill++;
                // full through an append: out at once, next row follows
                if (row_fill >= ROW_BYTES) begin
                    push_row_words();
                    open_row(row_end[31:0]);
                end
            end
        end else begin
            // beyond the row: flush it, then open the row of the new byte.
            // The prefix is shorter than a row, so the byte always fits;
            // landing on the last slot leaves a full row that stays open.
            if (row_fill != 0)
                push_row_words();
            open_row(it.address);
            row_img[row_fill] = it.data_byte;
            row_fill++;
        end
        // final beat of the item carries last
        if (row_out_q.size() > n0) begin
            tail      = row_out_q.pop_back();
            tail.last = 1'b1;
            row_out_q.push_back(tail);
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_byte(logic [31:0] addr, logic [7:0] data);
        fpk_pkg::t_in it;
        it.opcode    = fpk_pkg::OP_DATA;
        it.address   = addr;
        it.data_byte = data;
        item_q.push_back(it);
    endtask

    // Address and data of a flush are don't-care; keep them random.
    task automatic queue_flush();
        fpk_pkg::t_in it;
        it.opcode    = fpk_pkg::OP_FLUSH;
        it.address   = $urandom;
        it.data_byte = 8'($urandom_range(0, 255));
        item_q.push_back(it);
    endtask

    // Idle percentage by phase: the sender idles lightly while the receiver
    // idles heavily, then the reverse, then neither idles.
    function automatic int idle_pct(int unsigned cnt, bit rx);
        if (cnt < item_total / 3)
            return rx ? 85 : 30;
        else if (cnt < 2 * item_total / 3)
            return rx ? 30 : 85;
        else
            return 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one beat in flight. Valid holds until the beat is taken.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (item_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(sent_cnt, 1'b0)) begin
                in_valid <= 1'b1;
                in_beat  <= item_q.pop_front();
                sent_cnt <= sent_cnt + 1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= idle_pct(sent_cnt, 1'b1));
    end

    // ------------------------------------------------------------------
    // Monitor: check the output beat first, then predict the input beat.
    // A beat out at this edge always belongs to an earlier item.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        fpk_pkg::t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (row_out_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got %h", $time, out_beat);
                fail_cnt++;
            end else begin
                want = row_out_q.pop_front();
                check_field("row_address", want.row_address, out_beat.row_address);
                check_field("word_index", 32'(want.word_index), 32'(out_beat.word_index));
                check_field("row_word", want.row_word, out_beat.row_word);
                check_field("status", 32'(want.status), 32'(out_beat.status));
                check_field("last", 32'(want.last), 32'(out_beat.last));
            end
        end
        if (rst_n && in_valid && in_ready)
            pack_item(in_beat);
    end

    // Cycles since the last beat on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (rst_n);
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("tb_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] cursor;     // address of the latest byte in the run
        logic [31:0] noise;
        logic [32:0] tgt;
        int unsigned r;
        int unsigned step;

        // Directed: appends, gap fill, both kinds of backwards byte
        queue_byte(32'h0000_0000, 8'h00);
        queue_byte(32'h0000_0001, 8'hFF);
        queue_byte(32'h0000_0006, 8'hA5);   // blank gap of four
        queue_byte(32'h0000_0003, 8'h11);   // behind fill level
        queue_byte(32'h0000_0007, 8'h5A);
        queue_byte(32'h0000_1005, 8'h3C);   // beyond row, new row with prefix
        queue_byte(32'h0000_1000, 8'h01);   // inside the prefix: behind
        queue_byte(32'h0000_0FFF, 8'h02);   // below the row
        queue_flush();
        queue_flush();                      // empty row: no beat
        queue_byte(32'h0000_0010, 8'h55);   // below the flush row
        queue_byte(32'hFFFF_FF7F, 8'hC3);   // gap to the end, row goes out full
        queue_byte(32'hFFFF_FFFF, 8'hFF);   // top row full, wraps to zero
        queue_byte(32'h0000_207F, 8'h77);   // jump onto a row's last byte
        queue_byte(32'h0000_2070, 8'h66);   // that row is full: error
        queue_flush();                      // now it goes out
        queue_byte(32'hFFFF_FF83, 8'h42);
        queue_byte(32'hFFFF_FFFE, 8'h99);
        queue_byte(32'hFFFF_FFFF, 8'h00);   // full by append at the top, wrap
        queue_byte(32'h0000_0080, 8'hAB);
        queue_flush();                      // one word, blank tail

        // Random: ascending runs with gaps, forward jumps, flushes, some
        // backwards bytes and noise. Rows only move upward (or wrap after
        // the top row fills), so jumps stay forward and below the top row.
        cursor = fpk_pkg::FLUSH_BASE - 32'd1;
        repeat (RANDOM_ITEMS) begin
            r   = $urandom_range(0, 99);
            tgt = 33'h1_0000_0000;
            if (r < 3) begin
                queue_flush();
                cursor = fpk_pkg::FLUSH_BASE - 32'd1 + $urandom_range(0, 20);
            end else if (r < 7) begin
                queue_byte(cursor - $urandom_range(0, 8), 8'($urandom_range(0, 255)));
            end else if (r < 9) begin
                noise = $urandom;
                queue_byte(noise, 8'($urandom_range(0, 255)));
                if (noise > cursor && noise < 32'hFFFF_FF80)
                    cursor = noise;
            end else begin
                if (r < 15) begin
                    case ($urandom_range(0, 2))
                        0: tgt = {1'b0, cursor} + ROW_BYTES * $urandom_range(1, 4096)
                                 + $urandom_range(0, ROW_BYTES - 1);
                        // last byte of a row ahead: row full from the jump
                        1: tgt = ({1'b0, cursor} | (ROW_BYTES - 1)) + 1
                                 + ROW_BYTES * $urandom_range(0, 3) + (ROW_BYTES - 1);
                        default: tgt = {1'b0, cursor} + $urandom;
                    endcase
                end
                // no jump, or one into the top row: step ahead instead
                if (tgt >= 33'h0_FFFF_FF80) begin
                    r = $urandom_range(0, 99);
                    if (r < 65)
                        step = 1;
                    else if (r < 90)
                        step = $urandom_range(2, 8);
                    else
                        step = $urandom_range(9, 48);
                    if (cursor == 32'hFFFF_FFFF) begin
                        tgt = 33'(step) - 33'd1;     // top row filled, restart at zero
                    end else begin
                        tgt = {1'b0, cursor} + step;
                        if (tgt > 33'h0_FFFF_FFFF)
                            tgt = 33'h0_FFFF_FFFF;
                    end
                end
                cursor = tgt[31:0];
                queue_byte(cursor, 8'($urandom_range(0, 255)));
            end
        end
        item_total = item_q.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Everything sent and every predicted beat seen
        while (item_q.size() != 0 || in_valid || row_out_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_cnt == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/fpk_pkg.sv
hdl/fpk_ctrl.sv
hdl/fpk_dp.sv
hdl/flash_row_packer.sv
test/tb_top.sv
